// ----- sv/icsmu_pkg.sv -----
`default_nettype none
package icsmu_pkg;

	localparam int SCRATCH_BYTES = 4096;
	localparam int ADDR_W = $clog2(SCRATCH_BYTES);
	localparam int MAX_MATCH = 255;
	localparam int COUNT_W = $clog2(MAX_MATCH + 1);
	localparam int VALUE_W = 64;
	localparam int WADDR_W = 12;
	localparam int BYTE_W = 8;

	typedef enum logic [2:0] {
		OP_LT    = 3'd0,
		OP_GT    = 3'd1,
		OP_EQ    = 3'd2,
		OP_MATCH = 3'd3
	} op_t;

	typedef enum logic {
		REQ_WRITE   = 1'b0,
		REQ_COMPARE = 1'b1
	} req_t;

	// controller to datapath
	typedef struct packed {
		logic clr;    // zero one scratchpad byte
		logic wr;     // store the request byte
		logic cap;    // capture compare request
		logic adv;    // advance both walk pointers
		logic cnt;    // count one matched pair
		logic fin;    // close the walk
		logic load;   // move the result to the output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_cmp;
		logic is_match;
		logic eq;
		logic count_last;
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- sv/icsmu_dp.sv -----
`default_nettype none
module icsmu_dp (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  icsmu_pkg::dp_cmd_t                       cmd,
	output icsmu_pkg::dp_sts_t                       sts,
	input  logic                                     req_type,
	input  logic [2:0]                               op,
	input  logic signed [icsmu_pkg::VALUE_W-1:0]     operand_a,
	input  logic signed [icsmu_pkg::VALUE_W-1:0]     operand_b,
	input  logic [icsmu_pkg::WADDR_W-1:0]            write_address,
	input  logic [icsmu_pkg::BYTE_W-1:0]             write_byte,
	output logic signed [icsmu_pkg::VALUE_W-1:0]     result_value,
	output logic                                     bad_op
);
	import icsmu_pkg::*;

	logic [BYTE_W-1:0]  mem [SCRATCH_BYTES];
	logic [BYTE_W-1:0]  rd_a_q;
	logic [BYTE_W-1:0]  rd_b_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  pa_q;
	logic [ADDR_W-1:0]  pb_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_fin;
	logic [VALUE_W-1:0] val_q;
	logic               bad_q;
	logic [VALUE_W-1:0] flag;
	logic               bad;

	always_comb begin
		flag = '0;
		bad = 1'b0;
		case (op_t'(op))
			OP_LT:    flag = VALUE_W'(operand_a < operand_b);
			OP_GT:    flag = VALUE_W'(operand_b < operand_a);
			OP_EQ:    flag = VALUE_W'(operand_a == operand_b);
			OP_MATCH: flag = '0;
			default:  bad = 1'b1;
		endcase
	end

	assign count_fin = (rd_a_q == rd_b_q) ? count_q + COUNT_W'(1) : count_q;

	assign sts.clr_last   = &clr_q;
	assign sts.is_cmp     = (req_t'(req_type) == REQ_COMPARE);
	assign sts.is_match   = (op_t'(op) == OP_MATCH);
	assign sts.eq         = (rd_a_q == rd_b_q);
	assign sts.count_last = (count_q == COUNT_W'(MAX_MATCH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// single write port shared by the clearing pass and byte writes
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr) begin
			mem[write_address[ADDR_W-1:0]] <= write_byte;
		end
		rd_a_q <= mem[pa_q];
		rd_b_q <= mem[pb_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			pa_q    <= operand_a[ADDR_W-1:0];
			pb_q    <= operand_b[ADDR_W-1:0];
			count_q <= '0;
			val_q   <= flag;
			bad_q   <= bad;
		end else begin
			if (cmd.adv) begin
				pa_q <= pa_q + ADDR_W'(1);
				pb_q <= pb_q + ADDR_W'(1);
			end
			if (cmd.cnt) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (cmd.fin) begin
				// matched count minus one, all ones when nothing matched
				val_q <= VALUE_W'(count_fin) - VALUE_W'(1);
			end
		end
		if (cmd.load) begin
			result_value <= val_q;
			bad_op       <= bad_q;
		end
	end

endmodule
`default_nettype wire

// ----- sv/icsmu_ctrl.sv -----
`default_nettype none
module icsmu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  icsmu_pkg::dp_sts_t  sts,
	output icsmu_pkg::dp_cmd_t  cmd
);
	import icsmu_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_FETCH = 5'b00100,
		S_WALK  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_valid_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (!sts.is_cmp) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.cap = 1'b1;
						state_d = sts.is_match ? S_FETCH : S_EMIT;
					end
				end
			end
			S_FETCH: begin
				cmd.adv = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				// next pair is already being read while this one is checked
				if (sts.eq && !sts.count_last) begin
					cmd.adv = 1'b1;
					cmd.cnt = 1'b1;
				end else begin
					cmd.fin = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.load) begin
			out_valid_d = 1'b1;
		end else begin
			out_valid_d = out_valid_q && out_stall;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/integer_compare_and_string_match_unit_core.sv -----
`default_nettype none
// channel   valid      stall      payload
// in        in_valid   in_stall   req_type, op, operand_a, operand_b, write_address, write_byte
// out       out_valid  out_stall  result_value, bad_op
//
// a byte write request is taken and gives no result
// lt, gt, eq and bad op: flag registered, then loaded to the output; no new request till then
// string match: n pairs matched, at most 255, one byte pair per cycle through two
//   registered read ports; the walk ends at a mismatch or at 255 matched pairs
// after reset a clearing pass zeroes the scratchpad with in_stall high
// a request is taken while an earlier result still waits under out_stall
module integer_compare_and_string_match_unit_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic [2:0]                            op,
	input  logic signed [icsmu_pkg::VALUE_W-1:0]  operand_a,
	input  logic signed [icsmu_pkg::VALUE_W-1:0]  operand_b,
	input  logic [icsmu_pkg::WADDR_W-1:0]         write_address,
	input  logic [icsmu_pkg::BYTE_W-1:0]          write_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [icsmu_pkg::VALUE_W-1:0]  result_value,
	output logic                                  bad_op
);
	import icsmu_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	icsmu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	icsmu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.op            (op),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.write_address (write_address),
		.write_byte    (write_byte),
		.result_value  (result_value),
		.bad_op        (bad_op)
	);

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import icsmu_pkg::*;

	localparam logic [2:0] OP_RSVD_LO = 3'd4;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ALL_ONES = '1;
	localparam logic [63:0] NO_MATCH = '1;
	localparam logic [63:0] LONGEST = 64'(MAX_MATCH - 1);
	localparam int N_DIRECTED = 25;
	localparam int N_REQUESTS = 1600;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		req_t              kind;
		logic [2:0]        code;
		logic [63:0]       a;
		logic [63:0]       b;
		logic [WADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wbyte;
		logic              typed;
		logic [63:0]       want_val;
		logic              want_bad;
	} req_row_t;

	typedef struct packed {
		logic [63:0] val;
		logic        bad;
	} cmp_result_t;

	// kind, op, a, b, write address, write byte, typed, value, bad op
	localparam req_row_t DIRECTED [N_DIRECTED] = '{
		'{REQ_COMPARE, OP_MATCH, 64'd0, 64'd0, 12'd0, 8'd0, 1'b1, LONGEST, 1'b0},
		'{REQ_COMPARE, OP_MATCH, 64'd5, 64'h1005, 12'd0, 8'd0, 1'b1, LONGEST, 1'b0},
		'{REQ_COMPARE, OP_LT, S64_MIN, S64_MAX, 12'd0, 8'd0, 1'b1, 64'd1, 1'b0},
		'{REQ_COMPARE, OP_GT, S64_MIN, S64_MAX, 12'd0, 8'd0, 1'b1, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_EQ, S64_MAX, S64_MAX, 12'd0, 8'd0, 1'b1, 64'd1, 1'b0},
		'{REQ_COMPARE, OP_LT, S64_MAX, S64_MIN, 12'd0, 8'd0, 1'b1, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_GT, S64_MAX, S64_MIN, 12'd0, 8'd0, 1'b1, 64'd1, 1'b0},
		'{REQ_COMPARE, OP_EQ, ALL_ONES, ALL_ONES, 12'd0, 8'd0, 1'b1, 64'd1, 1'b0},
		'{REQ_COMPARE, OP_LT, ALL_ONES, 64'd0, 12'd0, 8'd0, 1'b1, 64'd1, 1'b0},
		'{REQ_COMPARE, OP_EQ, 64'd0, S64_MIN, 12'd0, 8'd0, 1'b1, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_RSVD_LO, S64_MAX, ALL_ONES, 12'd0, 8'd0, 1'b1, 64'd0, 1'b1},
		'{REQ_COMPARE, OP_RSVD_HI, S64_MIN, 64'd0, 12'hFFF, 8'hFF, 1'b1, 64'd0, 1'b1},
		'{REQ_WRITE, OP_LT, 64'd0, 64'd0, 12'hFFF, 8'hFF, 1'b0, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_MATCH, 64'hFFF, 64'd0, 12'd0, 8'd0, 1'b1, NO_MATCH, 1'b0},
		'{REQ_WRITE, OP_LT, 64'd0, 64'd0, 12'd0, 8'hFF, 1'b0, 64'd0, 1'b0},
		// walk wraps from the top byte to byte zero
		'{REQ_COMPARE, OP_MATCH, 64'hFFF, 64'd0, 12'd0, 8'd0, 1'b1, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_MATCH, ALL_ONES, S64_MIN, 12'd0, 8'd0, 1'b1, 64'd0, 1'b0},
		'{REQ_WRITE, OP_LT, 64'd0, 64'd0, 12'd100, 8'h5A, 1'b0, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_MATCH, 64'd100, 64'd3000, 12'd0, 8'd0, 1'b1, NO_MATCH, 1'b0},
		'{REQ_WRITE, OP_RSVD_HI, ALL_ONES, S64_MIN, 12'd3000, 8'h5A, 1'b0, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_MATCH, 64'd100, 64'd3000, 12'd0, 8'd0, 1'b1, LONGEST, 1'b0},
		'{REQ_COMPARE, OP_EQ, 64'd5, 64'd5, 12'hFFF, 8'h00, 1'b1, 64'd1, 1'b0},
		'{REQ_COMPARE, OP_MATCH, 64'hFFF, 64'd0, 12'd0, 8'd0, 1'b1, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_GT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
			12'd0, 8'd0, 1'b0, 64'd0, 1'b0},
		'{REQ_COMPARE, OP_LT, 64'h7FFF_FFFF_FFFF_FFFE, S64_MAX,
			12'd0, 8'd0, 1'b0, 64'd0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic [2:0] op;
	logic signed [VALUE_W-1:0] operand_a;
	logic signed [VALUE_W-1:0] operand_b;
	logic [WADDR_W-1:0] write_address;
	logic [BYTE_W-1:0] write_byte;
	logic out_valid;
	logic out_stall;
	logic signed [VALUE_W-1:0] result_value;
	logic bad_op;

	bit [BYTE_W-1:0] pad_model [SCRATCH_BYTES];
	cmp_result_t pending_results [$];
	int errors = 0;
	int sent = 0;
	int drained = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;

	integer_compare_and_string_match_unit_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.op           (op),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.write_address(write_address),
		.write_byte   (write_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.bad_op       (bad_op)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] match_len_less_one(input logic [63:0] a, input logic [63:0] b);
		logic [ADDR_W-1:0] pa;
		logic [ADDR_W-1:0] pb;
		logic [63:0] n;
		pa = a[ADDR_W-1:0];
		pb = b[ADDR_W-1:0];
		n = '0;
		while (n < MAX_MATCH && pad_model[pa] == pad_model[pb]) begin
			n++;
			pa++;
			pb++;
		end
		return n - 64'd1;
	endfunction

	function automatic cmp_result_t predict_compare(input logic [2:0] code,
			input logic signed [63:0] a, input logic signed [63:0] b);
		cmp_result_t r;
		r.bad = 1'b0;
		case (code)
			OP_LT:    r.val = (a < b) ? 64'd1 : 64'd0;
			OP_GT:    r.val = (a > b) ? 64'd1 : 64'd0;
			OP_EQ:    r.val = (a == b) ? 64'd1 : 64'd0;
			OP_MATCH: r.val = match_len_less_one(a, b);
			default: begin
				r.val = 64'd0;
				r.bad = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return S64_MIN;
			1: return S64_MAX;
			2: return 64'(signed'($urandom_range(0, 6)) - 3);
			3: return S64_MIN + 64'($urandom_range(0, 3));
			default: return rand64();
		endcase
	endfunction

	// compare request with noise in the write fields
	function automatic req_row_t cmp_row(input logic [2:0] code, input logic [63:0] a,
			input logic [63:0] b);
		req_row_t row;
		row = '0;
		row.kind = REQ_COMPARE;
		row.code = code;
		row.a = a;
		row.b = b;
		row.waddr = WADDR_W'($urandom);
		row.wbyte = BYTE_W'($urandom);
		return row;
	endfunction

	// write request with noise in the compare fields
	function automatic req_row_t write_row(input logic [WADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] value);
		req_row_t row;
		row = '0;
		row.kind = REQ_WRITE;
		row.code = 3'($urandom);
		row.a = rand64();
		row.b = rand64();
		row.waddr = addr;
		row.wbyte = value;
		return row;
	endfunction

	task automatic send_req(input req_row_t row);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= row.kind;
		op <= row.code;
		operand_a <= row.a;
		operand_b <= row.b;
		write_address <= row.waddr;
		write_byte <= row.wbyte;
		do @(posedge clk); while (in_stall);
		sent++;
		if (row.kind == REQ_WRITE)
			pad_model[row.waddr] = row.wbyte;
		else if (row.typed)
			pending_results.push_back('{row.want_val, row.want_bad});
		else
			pending_results.push_back(predict_compare(row.code, row.a, row.b));
	endtask

	// result side: check, then decide the stall for the coming cycles
	initial begin : drain
		int wait_left;
		cmp_result_t want;
		wait_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				drained++;
				if (pending_results.size() == 0) begin
					$error("result with no request pending: result_value %0d", result_value);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (result_value !== want.val) begin
						$error("result_value: expected %0d, actual %0d",
							$signed(want.val), result_value);
						errors++;
					end
					if (bad_op !== want.bad) begin
						$error("bad_op: expected %0b, actual %0b", want.bad, bad_op);
						errors++;
					end
				end
				wait_left = calm ? 0 : $urandom_range(0, 12);
				// one long hold-off so the block backs up into its input
				if (drained == 150)
					wait_left = HOLD_OFF_CYCLES;
			end
			@(negedge clk);
			if (wait_left > 0) begin
				out_stall <= 1'b1;
				wait_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [WADDR_W-1:0] src;
		logic [WADDR_W-1:0] dst;
		logic [BYTE_W-1:0] value;
		logic [63:0] a;
		logic [63:0] b;
		int len;
		int k;
		bit narrow;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_WRITE;
		op = OP_LT;
		operand_a = '0;
		operand_b = '0;
		write_address = '0;
		write_byte = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_req(DIRECTED[i]);

		while (sent < N_REQUESTS) begin
			if ($urandom_range(0, 39) == 0)
				calm = ($urandom_range(0, 3) == 0);
			k = $urandom_range(0, 99);
			if (k < 30) begin
				// copy a run of bytes, maybe spoil it, then match the two copies
				src = WADDR_W'($urandom);
				dst = WADDR_W'($urandom);
				len = $urandom_range(1, 40);
				narrow = 1'($urandom);
				for (int i = 0; i < len; i++) begin
					value = narrow ? BYTE_W'($urandom_range(0, 1)) : BYTE_W'($urandom);
					send_req(write_row(src + WADDR_W'(i), value));
					send_req(write_row(dst + WADDR_W'(i), value));
				end
				if ($urandom_range(0, 3) == 0)
					send_req(write_row(src + WADDR_W'($urandom_range(0, len - 1)),
						BYTE_W'($urandom)));
				k = $urandom_range(0, len - 1);
				a = rand64();
				a[ADDR_W-1:0] = src + WADDR_W'(k);
				b = rand64();
				b[ADDR_W-1:0] = dst + WADDR_W'(k);
				if ($urandom_range(0, 1))
					send_req(cmp_row(OP_MATCH, a, b));
				else
					send_req(cmp_row(OP_MATCH, b, a));
			end else if (k < 60) begin
				a = pick_operand();
				case ($urandom_range(0, 4))
					0: b = a;
					1: b = a + 64'd1;
					2: b = a - 64'd1;
					default: b = pick_operand();
				endcase
				send_req(cmp_row(3'($urandom_range(OP_LT, OP_EQ)), a, b));
			end else if (k < 66) begin
				send_req(cmp_row(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), rand64(), rand64()));
			end else if (k < 78) begin
				send_req(cmp_row(OP_MATCH, rand64(), rand64()));
			end else begin
				send_req(write_row(WADDR_W'($urandom), BYTE_W'($urandom)));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
